/* hdl/lwnp_pkg.sv */
// shared constants, types and the arctangent table of the nearest point search
package lwnp_pkg;

    localparam int MAX_SAMPLES   = 1024;
    localparam int ADDR_W        = $clog2(MAX_SAMPLES);
    localparam int CNT_W         = $clog2(MAX_SAMPLES + 1);

    localparam int CORDIC_STAGES = 16;
    localparam int ITER_W        = $clog2(CORDIC_STAGES);
    localparam int XW            = 36;
    localparam int ZW            = 34;
    localparam int GAIN_Q16      = 39797;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam logic [CFG_IDX_W-1:0] REG_START_BEARING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEARING_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_DIST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE     = 3'd4;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic               start;
        logic [15:0]        radius;
        logic signed [15:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [16:0] x;
        logic signed [16:0] y;
    } cordic_rsp_t;

    // arctangent of 2^-i, 2^32 units per turn
    function automatic logic signed [ZW-1:0] atan_units(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        atan_units = ZW'(val);
    endfunction

endpackage

/* hdl/lwnp_scan_store.sv */
// range store of one scan with its fill count and a registered read port
module lwnp_scan_store
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic                        wr_first,
    input  logic [15:0]                 wr_data,
    input  logic                        rd_en,
    input  logic [lwnp_pkg::ADDR_W-1:0] rd_addr,
    output logic [15:0]                 rd_data,
    output logic [lwnp_pkg::CNT_W-1:0]  count
);

    logic [15:0]                mem [lwnp_pkg::MAX_SAMPLES];
    logic [lwnp_pkg::CNT_W-1:0] cnt_reg;
    logic [lwnp_pkg::CNT_W-1:0] cnt_next;
    logic [15:0]                rd_data_reg;
    logic                       full;
    logic                       store_en;
    logic [lwnp_pkg::ADDR_W-1:0] wr_addr;

    assign full     = (cnt_reg == lwnp_pkg::CNT_W'(lwnp_pkg::MAX_SAMPLES));
    assign store_en = wr_en && (wr_first || !full);
    assign wr_addr  = wr_first ? '0 : cnt_reg[lwnp_pkg::ADDR_W-1:0];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (store_en)
        begin
            cnt_next = wr_first ? lwnp_pkg::CNT_W'(1) : cnt_reg + lwnp_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = cnt_reg;

endmodule

/* hdl/lwnp_cordic.sv */
// iterative cordic rotation of a distance to x and y, one stage per cycle
module lwnp_cordic
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lwnp_pkg::cordic_req_t req,
    output lwnp_pkg::cordic_rsp_t rsp
);

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_ITER  = 2'd1;
    localparam logic [1:0] C_FINAL = 2'd2;

    logic [1:0]                        state_reg;
    logic [1:0]                        state_next;
    logic [lwnp_pkg::ITER_W-1:0]       iter_reg;
    logic [lwnp_pkg::ITER_W-1:0]       iter_next;
    logic signed [lwnp_pkg::XW-1:0]    x_reg;
    logic signed [lwnp_pkg::XW-1:0]    x_next;
    logic signed [lwnp_pkg::XW-1:0]    y_reg;
    logic signed [lwnp_pkg::XW-1:0]    y_next;
    logic signed [lwnp_pkg::ZW-1:0]    z_reg;
    logic signed [lwnp_pkg::ZW-1:0]    z_next;
    logic                              done_reg;
    logic                              done_next;
    logic signed [16:0]                xo_reg;
    logic signed [16:0]                xo_next;
    logic signed [16:0]                yo_reg;
    logic signed [16:0]                yo_next;

    logic                              flip;
    logic signed [15:0]                b_adj;
    logic signed [16:0]                gain;
    logic signed [33:0]                prod;
    logic signed [31:0]                z_start;
    logic signed [lwnp_pkg::XW-1:0]    dx;
    logic signed [lwnp_pkg::XW-1:0]    dy;

    function automatic logic signed [16:0] round_sat(input logic signed [lwnp_pkg::XW-1:0] v);
        logic signed [lwnp_pkg::XW-1:0] r;
        r = (v + lwnp_pkg::XW'(32768)) >>> 16;
        if (r > lwnp_pkg::XW'(65535))
        begin
            round_sat = 17'sd65535;
        end
        else if (r < -lwnp_pkg::XW'(65536))
        begin
            round_sat = -17'sd65536;
        end
        else
        begin
            round_sat = r[16:0];
        end
    endfunction

    // angles beyond a quarter turn fold back by a half turn with the vector negated
    assign flip    = (req.angle > 16'sd16384) || (req.angle < -16'sd16384);
    assign b_adj   = flip ? {~req.angle[15], req.angle[14:0]} : req.angle;
    assign gain    = flip ? -17'(lwnp_pkg::GAIN_Q16) : 17'(lwnp_pkg::GAIN_Q16);
    assign prod    = $signed({1'b0, req.radius}) * gain;
    assign z_start = {b_adj, 16'h0000};

    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        done_next  = 1'b0;
        xo_next    = xo_reg;
        yo_next    = yo_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (req.start)
                begin
                    x_next     = lwnp_pkg::XW'(prod);
                    y_next     = '0;
                    z_next     = lwnp_pkg::ZW'(z_start);
                    iter_next  = '0;
                    state_next = C_ITER;
                end
            end
            C_ITER:
            begin
                if (!z_reg[lwnp_pkg::ZW-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - lwnp_pkg::atan_units(5'(iter_reg));
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + lwnp_pkg::atan_units(5'(iter_reg));
                end
                iter_next = iter_reg + lwnp_pkg::ITER_W'(1);
                if (iter_reg == lwnp_pkg::ITER_W'(lwnp_pkg::CORDIC_STAGES - 1))
                begin
                    state_next = C_FINAL;
                end
            end
            C_FINAL:
            begin
                xo_next    = round_sat(x_reg);
                yo_next    = round_sat(y_reg);
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iter_reg <= iter_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        xo_reg   <= xo_next;
        yo_reg   <= yo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.x    = xo_reg;
    assign rsp.y    = yo_reg;

endmodule

/* hdl/lidar_window_nearest_point.sv */
// top level: nearest point in a bearing window of a stored lidar scan
//
// input beats on s_*: tuser[0] kind (0 sample, 1 query), tuser[1] first sample flag,
// tdata[15:0] range in mm, tdata[31:16] target bearing (signed, 65536 per turn).
// a sample beat is stored when accepted; a first-sample beat restarts the scan and
// samples beyond the store depth are dropped. a query walks the stored samples one
// per cycle through the store's single read port, then, on a hit, runs the shared
// cordic stage once per cycle. s_tready is low while a query is in progress; samples
// are taken while a result still waits on m_*. a second query waits for the output
// register before its result is written there, and s_tready stays low while it waits,
// so a stalled receiver can stall samples as well as queries.
// m_tdata[16:0] x in mm, m_tdata[33:17] y in mm, m_tuser found flag.
// registers are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while idle, as the block itself does not enforce it.
// reset empties the scan store (fill count zero, no clearing pass) and loads the
// register defaults.
module lidar_window_nearest_point
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // range_mm, target_bearing
    input  logic [1:0]                        s_tuser,   // kind, first_sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,   // x_mm, y_mm, zero fill
    output logic                              m_tuser,   // found
    input  logic                              cfg_we,
    input  logic [lwnp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lwnp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WALK = 3'd1;
    localparam logic [2:0] ST_ROT  = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;

    logic signed [15:0]  start_bearing_reg;
    logic signed [12:0]  bearing_step_reg;
    logic [13:0]         half_width_reg;
    logic [15:0]         init_dist_reg;
    logic [15:0]         min_range_reg;

    logic [2:0]                      state_reg;
    logic [2:0]                      state_next;
    logic [lwnp_pkg::CNT_W-1:0]      n_reg;
    logic [lwnp_pkg::CNT_W-1:0]      n_next;
    logic [15:0]                     bacc_reg;
    logic [15:0]                     bacc_next;
    logic signed [15:0]              bpipe_reg;
    logic signed [15:0]              bpipe_next;
    logic                            rd_vld_reg;
    logic                            rd_vld_next;
    logic signed [16:0]              lo_reg;
    logic signed [16:0]              lo_next;
    logic signed [16:0]              hi_reg;
    logic signed [16:0]              hi_next;
    logic [15:0]                     best_reg;
    logic [15:0]                     best_next;
    logic signed [15:0]              best_b_reg;
    logic signed [15:0]              best_b_next;
    logic                            hit_reg;
    logic                            hit_next;
    logic signed [16:0]              res_x_reg;
    logic signed [16:0]              res_x_next;
    logic signed [16:0]              res_y_reg;
    logic signed [16:0]              res_y_next;
    logic                            res_found_reg;
    logic                            res_found_next;
    logic                            m_valid_reg;
    logic                            m_valid_next;
    logic signed [16:0]              m_x_reg;
    logic signed [16:0]              m_x_next;
    logic signed [16:0]              m_y_reg;
    logic signed [16:0]              m_y_next;
    logic                            m_found_reg;
    logic                            m_found_next;

    logic                            in_beat;
    logic                            sample_beat;
    logic                            query_beat;
    logic signed [16:0]              target_ext;
    logic signed [16:0]              b_ext;
    logic                            issue;
    logic                            qualify;
    logic [15:0]                     rd_data;
    logic [lwnp_pkg::CNT_W-1:0]      count;
    lwnp_pkg::cordic_req_t           creq;
    lwnp_pkg::cordic_rsp_t           crsp;

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_beat     = s_tvalid && s_tready;
    assign sample_beat = in_beat && (s_tuser[0] == lwnp_pkg::KIND_SAMPLE);
    assign query_beat  = in_beat && (s_tuser[0] == lwnp_pkg::KIND_QUERY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_bearing_reg <= 16'sd0;
            bearing_step_reg  <= 13'sd182;
            half_width_reg    <= 14'd910;
            init_dist_reg     <= 16'd10000;
            min_range_reg     <= 16'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lwnp_pkg::REG_START_BEARING: start_bearing_reg <= cfg_data;
                lwnp_pkg::REG_BEARING_STEP:  bearing_step_reg  <= cfg_data[12:0];
                lwnp_pkg::REG_HALF_WIDTH:    half_width_reg    <= cfg_data[13:0];
                lwnp_pkg::REG_INIT_DIST:     init_dist_reg     <= cfg_data;
                lwnp_pkg::REG_MIN_RANGE:     min_range_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    lwnp_scan_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (sample_beat),
        .wr_first (s_tuser[1]),
        .wr_data  (s_tdata[15:0]),
        .rd_en    (issue),
        .rd_addr  (n_reg[lwnp_pkg::ADDR_W-1:0]),
        .rd_data  (rd_data),
        .count    (count)
    );

    lwnp_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    assign target_ext = {s_tdata[31], s_tdata[31:16]};
    assign b_ext      = {bpipe_reg[15], bpipe_reg};
    assign issue      = (state_reg == ST_WALK) && (n_reg < count);
    // window test in wide integers, no wrap at the half turn
    assign qualify    = rd_vld_reg && (b_ext >= lo_reg) && (b_ext <= hi_reg)
                        && (rd_data > min_range_reg) && (rd_data < best_reg);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        bacc_next      = bacc_reg;
        bpipe_next     = bpipe_reg;
        rd_vld_next    = 1'b0;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        best_next      = best_reg;
        best_b_next    = best_b_reg;
        hit_next       = hit_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_found_next = res_found_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_x_next       = m_x_reg;
        m_y_next       = m_y_reg;
        m_found_next   = m_found_reg;
        creq.start     = 1'b0;
        creq.radius    = best_reg;
        creq.angle     = best_b_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_beat)
                begin
                    lo_next    = target_ext - {3'b000, half_width_reg};
                    hi_next    = target_ext + {3'b000, half_width_reg};
                    n_next     = '0;
                    bacc_next  = start_bearing_reg;
                    best_next  = init_dist_reg;
                    hit_next   = 1'b0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (issue)
                begin
                    n_next      = n_reg + lwnp_pkg::CNT_W'(1);
                    bacc_next   = bacc_reg + {{3{bearing_step_reg[12]}}, bearing_step_reg};
                    bpipe_next  = bacc_reg;
                    rd_vld_next = 1'b1;
                end
                if (qualify)
                begin
                    best_next   = rd_data;
                    best_b_next = bpipe_reg;
                    hit_next    = 1'b1;
                end
                if (!issue && !rd_vld_reg)
                begin
                    if (hit_reg)
                    begin
                        creq.start = 1'b1;
                        state_next = ST_ROT;
                    end
                    else
                    begin
                        res_x_next     = {1'b0, init_dist_reg};
                        res_y_next     = '0;
                        res_found_next = 1'b0;
                        state_next     = ST_DONE;
                    end
                end
            end
            ST_ROT:
            begin
                if (crsp.done)
                begin
                    res_x_next     = crsp.x;
                    res_y_next     = crsp.y;
                    res_found_next = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_x_next     = res_x_reg;
                    m_y_next     = res_y_reg;
                    m_found_next = res_found_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_vld_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        bacc_reg      <= bacc_next;
        bpipe_reg     <= bpipe_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        best_reg      <= best_next;
        best_b_reg    <= best_b_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        res_found_reg <= res_found_next;
        m_x_reg       <= m_x_next;
        m_y_reg       <= m_y_next;
        m_found_reg   <= m_found_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b000000, m_y_reg, m_x_reg};
    assign m_tuser  = m_found_reg;

    // the rotation unit answers only while a rotation is awaited
    a_done_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
        crsp.done |-> (state_reg == ST_ROT))
        else $error("cordic done outside rotation wait");

    // a no-hit result carries a zero lateral coordinate
    a_nohit_y: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_found_reg) |-> (m_y_reg == 17'sd0))
        else $error("no-hit result with nonzero y");

    // a kept best range always passes the minimum range test
    a_best_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WALK) && hit_reg) |-> (best_reg > min_range_reg))
        else $error("best range at or below minimum");

    // the walk never reads past the fill count
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (n_reg <= count))
        else $error("walk index beyond fill count");

    // the fill count never exceeds the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= lwnp_pkg::CNT_W'(lwnp_pkg::MAX_SAMPLES))
        else $error("fill count beyond store depth");

endmodule

/* test/lidar_window_nearest_point_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the lidar window nearest point search
module lidar_window_nearest_point_tb;

    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASE_ITEMS   = 60;
    localparam int ATAN_ENTRIES  = 24;

    // arctangent of 2^-i in 2^32 units per turn, entry 0 in the low word
    localparam logic [ATAN_ENTRIES*32-1:0] ATAN_TURN = {
        32'h00000051, 32'h000000A3, 32'h00000146, 32'h0000028C, 32'h00000518, 32'h00000A30,
        32'h0000145F, 32'h000028BE, 32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
        32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53, 32'h00517C55, 32'h00A2F61E,
        32'h0145D7E1, 32'h028B0D43, 32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
    };

    typedef struct packed {
        logic               kind;
        logic               first;
        logic [15:0]        range_mm;
        logic signed [15:0] target;
    } scan_beat_t;

    typedef struct packed {
        logic signed [16:0] x_mm;
        logic signed [16:0] y_mm;
        logic               found;
    } point_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [31:0]                     s_tdata   = '0;
    logic [1:0]                      s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [39:0]                     m_tdata;
    logic                            m_tuser;
    logic                            cfg_we    = 1'b0;
    logic [lwnp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lwnp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // shadow of the registers and the scan store
    logic [15:0] cfg_start = 16'd0;
    logic [12:0] cfg_step  = 13'd182;
    logic [13:0] cfg_half  = 14'd910;
    logic [15:0] cfg_init  = 16'd10000;
    logic [15:0] cfg_min   = 16'd10;
    logic [15:0] scan_mem [lwnp_pkg::MAX_SAMPLES];
    int          scan_len  = 0;

    scan_beat_t beats_to_send [$];
    point_t     pending_points [$];
    int         beats_pushed = 0;
    int         beats_taken  = 0;
    int         plan_len     = 0;
    int         mismatches   = 0;
    bit         calm         = 1'b0;
    int         send_gap     = 0;
    int         sink_hold    = 0;
    int         quiet_cycles = 0;
    scan_beat_t next_beat;
    point_t     sink_want;

    lidar_window_nearest_point DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // range_mm, target_bearing
        .s_tuser   (s_tuser),   // kind, first_sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // x_mm, y_mm, zero fill
        .m_tuser   (m_tuser),   // found
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic [16:0] clip17(input longint v);
        if (v > 65535)
            v = 65535;
        if (v < -65536)
            v = -65536;
        return v[16:0];
    endfunction

    function automatic point_t nearest_point(input logic signed [15:0] target);
        longint             lo, hi, base, inc, bear, best_bear, x, y, z, dx, dy;
        logic signed [15:0] ang;
        logic [15:0]        best;
        bit                 hit;
        point_t             res;
        lo        = longint'(target) - longint'(cfg_half);
        hi        = longint'(target) + longint'(cfg_half);
        base      = longint'(signed'(cfg_start));
        inc       = longint'(signed'(cfg_step));
        best      = cfg_init;
        best_bear = 0;
        hit       = 1'b0;
        for (int n = 0; n < scan_len; n++)
        begin
            ang  = 16'(base + n * inc);
            bear = ang;
            if (bear >= lo && bear <= hi && scan_mem[n] > cfg_min && scan_mem[n] < best)
            begin
                best      = scan_mem[n];
                best_bear = bear;
                hit       = 1'b1;
            end
        end
        if (!hit)
        begin
            res.x_mm  = {1'b0, cfg_init};
            res.y_mm  = '0;
            res.found = 1'b0;
        end
        else
        begin
            x = longint'(best) * lwnp_pkg::GAIN_Q16;
            y = 0;
            // fold the angle into the right half plane first
            if (best_bear > 16384)
            begin
                best_bear -= 32768;
                x = -x;
            end
            else if (best_bear < -16384)
            begin
                best_bear += 32768;
                x = -x;
            end
            z = best_bear * 65536;
            for (int i = 0; i < lwnp_pkg::CORDIC_STAGES && i < ATAN_ENTRIES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= longint'(ATAN_TURN[i*32 +: 32]);
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += longint'(ATAN_TURN[i*32 +: 32]);
                end
            end
            res.x_mm  = clip17((x + 32768) >>> 16);
            res.y_mm  = clip17((y + 32768) >>> 16);
            res.found = 1'b1;
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [16:0] got,
                               input logic [16:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s is %0d, expected %0d", name,
                                    $signed(got), $signed(want)));
    endtask

    task automatic write_reg(input logic [lwnp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            lwnp_pkg::REG_START_BEARING: cfg_start = val;
            lwnp_pkg::REG_BEARING_STEP:  cfg_step  = val[12:0];
            lwnp_pkg::REG_HALF_WIDTH:    cfg_half  = val[13:0];
            lwnp_pkg::REG_INIT_DIST:     cfg_init  = val;
            lwnp_pkg::REG_MIN_RANGE:     cfg_min   = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] start_b, input logic [15:0] inc_b,
                              input logic [15:0] half_w, input logic [15:0] init_d,
                              input logic [15:0] min_r);
        write_reg(lwnp_pkg::REG_START_BEARING, start_b);
        write_reg(lwnp_pkg::REG_BEARING_STEP, inc_b);
        write_reg(lwnp_pkg::REG_HALF_WIDTH, half_w);
        write_reg(lwnp_pkg::REG_INIT_DIST, init_d);
        write_reg(lwnp_pkg::REG_MIN_RANGE, min_r);
    endtask

    task automatic push_sample(input logic [15:0] range_mm, input logic first);
        scan_beat_t b;
        b.kind     = lwnp_pkg::KIND_SAMPLE;
        b.first    = first;
        b.range_mm = range_mm;
        b.target   = 16'($urandom);
        beats_to_send.push_back(b);
        beats_pushed++;
        if (first)
            plan_len = 0;
        if (plan_len < lwnp_pkg::MAX_SAMPLES)
            plan_len++;
    endtask

    task automatic push_query(input logic [15:0] target);
        scan_beat_t b;
        b.kind     = lwnp_pkg::KIND_QUERY;
        b.first    = 1'($urandom);
        b.range_mm = 16'($urandom);
        b.target   = target;
        beats_to_send.push_back(b);
        beats_pushed++;
    endtask

    // target near the bearing of a stored sample, often right on a window edge
    function automatic logic [15:0] aimed_target();
        int k, base, half, off;
        if (plan_len == 0)
            return 16'($urandom);
        k    = $urandom_range(0, plan_len - 1);
        base = int'(signed'(cfg_start)) + k * int'(signed'(cfg_step));
        half = int'(cfg_half);
        case ($urandom_range(0, 7))
            0: off = half;
            1: off = -half;
            2: off = half + 1;
            3: off = -half - 1;
            default: off = int'($urandom_range(0, 2 * half)) - half;
        endcase
        return 16'(base + off);
    endfunction

    function automatic logic [15:0] pick_range(input logic [15:0] prev);
        case ($urandom_range(0, 11))
            0:       return cfg_min;
            1:       return cfg_min + 16'd1;
            2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            3:       return cfg_init;
            4:       return cfg_init - 16'd1;
            5:       return prev;
            6, 7, 8: return 16'($urandom_range(0, cfg_init));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_len();
        case ($urandom_range(0, 19))
            0:       return $urandom_range(100, 300);
            1:       return 1;
            default: return $urandom_range(1, 24);
        endcase
    endfunction

    task automatic wait_idle();
        while (beats_taken != beats_pushed || pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // source side: takes beats from the queue, shadows the store, predicts queries
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == lwnp_pkg::KIND_SAMPLE)
                begin
                    if (s_tuser[1])
                        scan_len = 0;
                    if (scan_len < lwnp_pkg::MAX_SAMPLES)
                    begin
                        scan_mem[scan_len] = s_tdata[15:0];
                        scan_len++;
                    end
                end
                else
                    pending_points.push_back(nearest_point(s_tdata[31:16]));
                beats_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 5) == 0)
                begin
                    send_gap <= $urandom_range(0, 8);
                    s_tvalid <= 1'b0;
                end
                else if (beats_to_send.size() != 0)
                begin
                    next_beat = beats_to_send.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {next_beat.target, next_beat.range_mm};
                    s_tuser   <= {next_beat.first, next_beat.kind};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // sink side: random back pressure and result checking
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_points.size() == 0)
                    flag_mismatch("result beat with no query waiting");
                else
                begin
                    sink_want = pending_points.pop_front();
                    check_field("x_mm", m_tdata[16:0], sink_want.x_mm);
                    check_field("y_mm", m_tdata[33:17], sink_want.y_mm);
                    check_field("found", {16'd0, m_tuser}, {16'd0, sink_want.found});
                end
            end
            if (sink_hold != 0)
                sink_hold <= sink_hold - 1;
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready  <= 1'b0;
                sink_hold <= $urandom_range(0, 8);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int          ph, items, len, nq, j;
        logic [15:0] prev_range;
        prev_range = 16'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset settings
        push_query(16'd0);                  // nothing stored yet
        push_sample(16'd0, 1'b1);
        push_sample(16'd10, 1'b0);          // equal to the minimum, ignored
        push_sample(16'd11, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'd500, 1'b0);
        push_sample(16'd500, 1'b0);
        push_sample(16'd9999, 1'b0);
        push_sample(16'd10000, 1'b0);       // equal to the start best, never taken
        push_query(16'd0);
        push_query(16'd1000);
        push_query(16'h7FFF);
        push_query(16'h8000);
        push_query(16'hFF4A);
        push_sample(16'd10000, 1'b1);
        push_query(16'd0);
        push_sample(16'd20, 1'b1);
        push_sample(16'd20, 1'b0);          // tie goes to the earlier sample
        push_query(16'd91);
        wait_idle();

        // writes beyond the register list change nothing
        for (int idx = int'(lwnp_pkg::REG_MIN_RANGE) + 1; idx < (1 << lwnp_pkg::CFG_IDX_W);
             idx++)
            write_reg(lwnp_pkg::CFG_IDX_W'(idx), 16'($urandom));
        push_query(16'd91);
        wait_idle();

        // fill the store past its depth, the overflow would win if it were kept
        set_config(16'h8000, 16'd64, 16'd16383, 16'hFFFF, 16'd10);
        for (j = 0; j < lwnp_pkg::MAX_SAMPLES; j++)
        begin
            prev_range = pick_range(prev_range);
            push_sample(prev_range, j == 0);
        end
        for (j = 0; j < 6; j++)
            push_sample(16'd11, 1'b0);
        for (j = 0; j < 3; j++)
            push_query(aimed_target());
        push_query(16'($urandom));
        wait_idle();

        for (ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
                calm = 1'b1;
            case (ph)
                0: set_config(16'h8000, 16'h1000, 16'd0, 16'hFFFF, 16'd0);
                1: set_config(16'h7FFF, 16'h0FFF, 16'h3FFF, 16'd0, 16'hFFFF);
                2: set_config(16'($urandom), 16'd0, 16'($urandom_range(0, 2000)),
                              16'hFFFF, 16'($urandom_range(0, 100)));
                default:
                    set_config(16'($urandom), 16'($urandom),
                               $urandom_range(0, 3) == 0 ? 16'h3FFF : 16'($urandom),
                               $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom),
                               $urandom_range(0, 5) == 0 ? 16'($urandom)
                                                         : 16'($urandom_range(0, 200)));
            endcase
            items = 0;
            while (items < PHASE_ITEMS)
            begin
                len = pick_len();
                case ($urandom_range(0, 9))
                    0:
                    begin
                        // samples appended to the current scan
                        for (j = 0; j < len; j++)
                        begin
                            prev_range = pick_range(prev_range);
                            push_sample(prev_range, 1'b0);
                        end
                        items += len;
                    end
                    1:
                    begin
                        push_query(16'($urandom));
                        items++;
                    end
                    default:
                    begin
                        // a fresh scan, now and then restarted in the middle
                        for (j = 0; j < len; j++)
                        begin
                            prev_range = pick_range(prev_range);
                            push_sample(prev_range, j == 0 || $urandom_range(0, 30) == 0);
                        end
                        nq = $urandom_range(1, 4);
                        for (j = 0; j < nq; j++)
                            push_query(aimed_target());
                        items += len + nq;
                    end
                endcase
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
hdl/lwnp_pkg.sv
hdl/lwnp_scan_store.sv
hdl/lwnp_cordic.sv
hdl/lidar_window_nearest_point.sv
test/lidar_window_nearest_point_tb.sv
